// ===== rtl/shs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum string hash package
// Constants and shared types for the streaming byte hash.
// ----------------------------------------------------------------------------
package shs_pkg;

    localparam int unsigned MAX_LENGTH = 65535;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_W   = 16;
    localparam int unsigned HASH_W  = 31;
    localparam int unsigned SHIFT_W = 5;

    localparam logic [31:0]        SEED_MULT  = 32'h238F13AF;
    localparam logic [31:0]        LCG_MULT   = 32'd1103515243;
    localparam logic [HASH_W-1:0]  LCG_ADD    = 31'd12345;
    localparam logic [SHIFT_W-1:0] SHIFT_STEP = 5'd5;
    localparam logic [SHIFT_W-1:0] SHIFT_MOD  = 5'd24;

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              first_item;
        logic              last_item;
        logic              empty_message;
        logic [HASH_W-1:0] seed;
    } shs_item_t;

endpackage

// ===== rtl/shs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum hash input stage
// Registers each input transfer together with the length-derived seed.
// ----------------------------------------------------------------------------
module shs_front
    import shs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  byte_value,
    input  logic               first_item,
    input  logic               last_item,
    input  logic [LEN_W-1:0]   message_length,
    input  logic               empty_message,
    output logic               item_valid,
    input  logic               item_ready,
    output shs_item_t          item
);

    logic             valid_reg;
    shs_item_t        item_reg;
    shs_item_t        item_next;
    logic [LEN_W-1:0] length_sat;

    always_comb
    begin
        length_sat = (32'(message_length) > MAX_LENGTH) ? LEN_W'(MAX_LENGTH)
                                                        : message_length;
        item_next.byte_value    = byte_value;
        item_next.first_item    = first_item;
        item_next.last_item     = last_item;
        item_next.empty_message = empty_message;
        item_next.seed          = SEED_MULT[HASH_W-1:0] * HASH_W'(length_sat);
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/shs_update.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum hash accumulator
// Holds the accumulator and shift position and updates them once per byte.
// ----------------------------------------------------------------------------
module shs_update
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  shs_item_t         item,
    output logic              fin_valid,
    input  logic              fin_ready,
    output logic [HASH_W-1:0] fin_acc
);

    logic [HASH_W-1:0]  acc_reg;
    logic [HASH_W-1:0]  acc_next;
    logic [SHIFT_W-1:0] shift_reg;
    logic [SHIFT_W-1:0] shift_next;
    logic               fin_valid_reg;
    logic [HASH_W-1:0]  fin_acc_reg;
    logic [SHIFT_W-1:0] shift_cur;
    logic [SHIFT_W-1:0] shift_inc;
    logic [HASH_W-1:0]  acc_base;
    logic [HASH_W-1:0]  extended;
    logic               advance;

    always_comb
    begin
        shift_cur = item.first_item ? '0 : shift_reg;
        acc_base  = item.first_item ? item.seed : acc_reg;
        extended  = {{(HASH_W - BYTE_W){item.byte_value[BYTE_W-1]}}, item.byte_value};
        shift_inc = shift_cur + SHIFT_STEP;
        if (item.empty_message)
        begin
            acc_next   = '0;
            shift_next = '0;
        end
        else
        begin
            acc_next   = acc_base + (extended << shift_cur);
            shift_next = (shift_inc >= SHIFT_MOD) ? shift_inc - SHIFT_MOD : shift_inc;
        end
    end

    assign item_ready = !fin_valid_reg || fin_ready;
    assign advance    = item_valid && item_ready;
    assign fin_valid  = fin_valid_reg;
    assign fin_acc    = fin_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            shift_reg     <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                acc_reg   <= acc_next;
                shift_reg <= shift_next;
            end
            if (item_ready)
            begin
                fin_valid_reg <= item_valid && (item.last_item || item.empty_message);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fin_acc_reg <= acc_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) shift_reg < SHIFT_MOD)
        else $error("shift position out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.empty_message |=> acc_reg == '0 && shift_reg == '0)
        else $error("empty message did not clear the state");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(acc_reg) && $stable(shift_reg))
        else $error("state changed without a byte transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.empty_message |=> fin_valid_reg && fin_acc_reg == '0)
        else $error("empty message result not queued");

endmodule

// ===== rtl/shs_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum hash finishing stage
// Applies the linear-congruential finish and holds the result for output.
// ----------------------------------------------------------------------------
module shs_finish
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fin_valid,
    output logic              fin_ready,
    input  logic [HASH_W-1:0] fin_acc,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HASH_W-1:0] hash_value
);

    logic              valid_reg;
    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] hash_next;

    assign hash_next  = LCG_MULT[HASH_W-1:0] * fin_acc + LCG_ADD;
    assign fin_ready  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign hash_value = hash_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_ready && fin_valid)
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== rtl/shifted_sum_string_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum string hash
// Streaming hash over a byte message, one byte per input transfer.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_ready   byte_value, first_item, last_item,
//                                   message_length, empty_message
//   output    out_valid / out_ready hash_value
//
// One byte is accepted per cycle while the output keeps up.
// A result passes the front, update and finish registers in turn.
// Loops: accumulator (one add of a shifted byte), shift position.
// Reset clears the accumulator, the shift position and all valid flags.
// A stalled output fills the two inner stages before input ready drops.
// ----------------------------------------------------------------------------
module shifted_sum_string_hash
    import shs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              first_item,
    input  logic              last_item,
    input  logic [LEN_W-1:0]  message_length,
    input  logic              empty_message,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [HASH_W-1:0] hash_value
);

    logic              item_valid;
    logic              item_ready;
    shs_item_t         item;
    logic              fin_valid;
    logic              fin_ready;
    logic [HASH_W-1:0] fin_acc;

    shs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .empty_message  (empty_message),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item)
    );

    shs_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_acc    (fin_acc)
    );

    shs_finish u_finish (
        .clk        (clk),
        .rst_n      (rst_n),
        .fin_valid  (fin_valid),
        .fin_ready  (fin_ready),
        .fin_acc    (fin_acc),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule

// ===== verif/tb_shifted_sum_string_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shifted-sum string hash testbench
// Sends byte messages through the input channel and predicts each 31-bit hash
// with a local copy of the running sum and shift position. Each output
// transfer is checked in order against the queue of predicted hashes.
// Directed cases cover stray bytes, empty messages, length extremes, shift
// wrap-around, length mismatches and a full-rate run. Random messages follow,
// with gaps and stalls of random length on both channels.
// ----------------------------------------------------------------------------
module tb_shifted_sum_string_hash;
    import shs_pkg::*;

    localparam int unsigned HALF_PERIOD  = 4;
    localparam int unsigned RANDOM_ITEMS = 1500;
    localparam int unsigned STALL_LIMIT  = 5000;
    localparam int unsigned DRAIN_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [BYTE_W-1:0] byte_value;
    logic              first_item;
    logic              last_item;
    logic [LEN_W-1:0]  message_length;
    logic              empty_message;
    logic              out_valid;
    logic              out_ready;
    logic [HASH_W-1:0] hash_value;

    logic [31:0]        running_sum;
    logic [SHIFT_W-1:0] shift_pos;
    logic [HASH_W-1:0]  pending_hashes[$];
    bit                 idling_enabled;
    int                 error_count;
    int                 sent_items;
    int                 quiet_cycles;
    int                 stall_left;

    shifted_sum_string_hash u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .byte_value     (byte_value),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .empty_message  (empty_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(HALF_PERIOD) clk = ~clk;

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idling_enabled || roll < 50)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [HASH_W-1:0] lcg_finish(input logic [31:0] acc);
        logic [31:0] mixed;
        mixed = LCG_MULT * acc + {1'b0, LCG_ADD};
        return mixed[HASH_W-1:0];
    endfunction

    task automatic absorb_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l,
                               input logic [LEN_W-1:0] len, input logic e);
        logic [31:0] seed_len;
        logic [31:0] widened;
        if (e)
        begin
            running_sum = '0;
            shift_pos   = '0;
            pending_hashes.push_back(lcg_finish(32'd0));
            return;
        end
        if (f)
        begin
            seed_len    = (len > MAX_LENGTH) ? MAX_LENGTH : {16'd0, len};
            running_sum = SEED_MULT * seed_len;
            shift_pos   = '0;
        end
        widened     = {{24{b[7]}}, b};
        running_sum = (running_sum + (widened << shift_pos)) & 32'h7FFF_FFFF;
        shift_pos   = shift_pos + SHIFT_STEP;
        if (shift_pos >= SHIFT_MOD)
            shift_pos = shift_pos - SHIFT_MOD;
        if (l)
            pending_hashes.push_back(lcg_finish(running_sum));
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic f, input logic l,
                             input logic [LEN_W-1:0] len, input logic e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       = 1'b1;
        byte_value     = b;
        first_item     = f;
        last_item      = l;
        message_length = len;
        empty_message  = e;
        do
            @(posedge clk);
        while (!in_ready);
        absorb_byte(b, f, l, len, e);
        sent_items++;
        @(negedge clk);
    endtask

    task automatic send_message(input int count, input logic [LEN_W-1:0] len);
        for (int i = 0; i < count; i++)
            send_byte(BYTE_W'($urandom_range(0, 255)), i == 0, i == count - 1, len, 1'b0);
    endtask

    task automatic wait_drain();
        in_valid = 1'b0;
        while (pending_hashes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_stray_bytes();
        send_byte(8'h81, 1'b0, 1'b0, 16'd0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b1, 16'd0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1, 16'hFFFF, 1'b0);
    endtask

    task automatic test_empty_message();
        send_byte(8'hFF, 1'b1, 1'b0, 16'hFFFF, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0, 16'd0, 1'b1);
        send_byte(8'h80, 1'b1, 1'b1, 16'd1, 1'b1);
    endtask

    task automatic test_length_extremes();
        send_byte(8'h80, 1'b1, 1'b1, 16'd1, 1'b0);
        send_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b0);
        send_byte(8'h7F, 1'b1, 1'b1, 16'd0, 1'b0);
    endtask

    task automatic test_shift_wrap();
        logic [BYTE_W-1:0] pattern[8];
        pattern = '{8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h00, 8'hAA, 8'h55};
        for (int i = 0; i < 8; i++)
            send_byte(pattern[i], i == 0, i == 7, 16'd8, 1'b0);
    endtask

    task automatic test_count_mismatch();
        send_message(4, 16'd3);
        send_message(2, 16'd9);
        send_byte(8'h5A, 1'b1, 1'b0, 16'd5, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b0, 16'd0, 1'b1);
        send_byte(8'h3C, 1'b0, 1'b1, 16'd0, 1'b0);
    endtask

    task automatic test_full_rate();
        int count;
        idling_enabled = 1'b0;
        for (int m = 0; m < 20; m++)
        begin
            count = $urandom_range(1, 12);
            send_message(count, LEN_W'(count));
        end
        idling_enabled = 1'b1;
    endtask

    task automatic test_random_messages();
        int stop_at;
        int count;
        int kind;
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at)
        begin
            idling_enabled = ($urandom_range(0, 7) != 0);
            kind = $urandom_range(0, 99);
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                 : $urandom_range(1, 12);
            if (kind < 75)
                send_message(count, LEN_W'(count));
            else if (kind < 82)
                send_message(count, LEN_W'($urandom_range(0, 65535)));
            else if (kind < 88)
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 65535)),
                          1'b1);
            else if (kind < 94)
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                          1'($urandom_range(0, 1)), LEN_W'($urandom_range(0, 65535)),
                          1'b0);
            else if (kind < 97)
                send_message(count, 16'd0);
            else
            begin
                send_message(count, LEN_W'(count));
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0,
                          1'($urandom_range(0, 1)), LEN_W'(count), 1'b0);
            end
        end
        idling_enabled = 1'b1;
    endtask

    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (idling_enabled && stall_left > 0)
            begin
                out_ready = 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready = 1'b1;
                if (idling_enabled && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_hashes.size() == 0)
            begin
                $error("hash_value: no transfer expected, actual %h", hash_value);
                error_count++;
            end
            else if (hash_value !== pending_hashes[0])
            begin
                $error("hash_value: expected %h, actual %h", pending_hashes[0], hash_value);
                error_count++;
                void'(pending_hashes.pop_front());
            end
            else
                void'(pending_hashes.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        byte_value     = '0;
        first_item     = 1'b0;
        last_item      = 1'b0;
        message_length = '0;
        empty_message  = 1'b0;
        idling_enabled = 1'b1;
        error_count    = 0;
        sent_items     = 0;
        quiet_cycles   = 0;
        running_sum    = '0;
        shift_pos      = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_stray_bytes();
        test_empty_message();
        test_length_extremes();
        test_shift_wrap();
        test_count_mismatch();
        test_full_rate();
        test_random_messages();
        wait_drain();

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/shs_pkg.sv
rtl/shs_front.sv
rtl/shs_update.sv
rtl/shs_finish.sv
rtl/shifted_sum_string_hash.sv
verif/tb_shifted_sum_string_hash.sv
